>>> hw/rtl/wcm_pkg.sv
package wcm_pkg;

  localparam int COORD_BITS = 32;
  localparam int INDEX_BITS = 16;
  localparam int W_BITS     = 32;
  localparam int PROD_BITS  = W_BITS + COORD_BITS;
  localparam int EXT_BITS   = (PROD_BITS > 64) ? PROD_BITS : 64;
  localparam int IN_BITS    = ((INDEX_BITS + W_BITS + 3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = ((INDEX_BITS + 3 * COORD_BITS + 7) / 8) * 8;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_CLAMP = 64'd1 << 50;
  localparam logic signed [63:0] CMAX = 64'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_REF    = 2'd1;
  localparam logic [1:0] KIND_MEMBER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {OP_ACC, OP_CEN, OP_GRAD} op_t;

  function automatic logic [63:0] sat_prod(input logic [PROD_BITS-1:0] p, input logic neg);
    logic [EXT_BITS-1:0] pe;
    logic [63:0] m;
    pe = EXT_BITS'(p);
    m = (pe > EXT_BITS'(S64_MAX)) ? S64_MAX : pe[63:0];
    return neg ? (64'd0 - m) : m;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [COORD_BITS-1:0] mag_coord(input logic [COORD_BITS-1:0] v);
    return v[COORD_BITS-1] ? (COORD_BITS'(0) - v) : v;
  endfunction

  function automatic logic [63:0] sext_coord(input logic [COORD_BITS-1:0] v);
    return {{(64 - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [63:0] v);
    if (v > CMAX) begin
      return CMAX[COORD_BITS-1:0];
    end
    if (v < CMIN) begin
      return CMIN[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/wcm_mul.sv
module wcm_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [wcm_pkg::W_BITS-1:0]       a,
  input  logic [wcm_pkg::COORD_BITS-1:0]   b,
  output logic                             done,
  output logic [wcm_pkg::PROD_BITS-1:0]    prod
);
  localparam int C  = wcm_pkg::COORD_BITS;
  localparam int W  = wcm_pkg::W_BITS;
  localparam int CB = $clog2(W);

  logic [C:0]   hi_r, hi_nxt;
  logic [W-1:0] lo_r, lo_nxt;
  logic [C-1:0] b_r, b_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [C:0] sum;

  always_comb begin
    sum = hi_r + (lo_r[0] ? {1'b0, b_r} : '0);
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    b_nxt = b_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt = '0;
      lo_nxt = a;
      b_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt = sum >> 1;
      lo_nxt = {sum[0], lo_r[W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CB'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r[C-1:0], lo_r};
endmodule

>>> hw/rtl/wcm_div.sv
module wcm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [63:0]                num,
  input  logic [wcm_pkg::W_BITS-1:0] den,
  output logic                       done,
  output logic [63:0]                quo
);
  localparam int W = wcm_pkg::W_BITS;

  logic [W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [W+1:0] trial;
  logic ge;

  always_comb begin
    trial = {1'b0, rem_r, quo_r[63]} - {2'b00, den_r};
    ge = !trial[W+1];
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      den_nxt = den;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[W-1:0] : {rem_r[W-2:0], quo_r[63]};
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = quo_r;
endmodule

>>> hw/rtl/weighted_center_of_mass_core.sv
// channel  dir  handshake                tdata / tuser
// in       in   in_tvalid/in_tready      item fields, tuser=action, tlast=last_in_group
// out      out  out_tvalid/out_tready    result fields, tuser={zero_weight,kind}
// cfg      in   cfg_wen                  cfg_wdata = mode
// Forward member: the bit-serial multiplier runs once per axis; a group end adds a division per axis.
// Backward member: for each axis, the multiplier and then the bit-serial divider.
// Header: forward it loads the group (plus a division per axis when marked last); backward it goes straight out.
// Synchronous active-low reset clears mode, group state and the output valid flag.
// The next request is taken while a result waits; a new result stalls until out is free.
module weighted_center_of_mass_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // atom_index, weight, vec_x, vec_y, vec_z
  input  logic [wcm_pkg::IN_BITS-1:0]   in_tdata,
  // action
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // target_index, out_x, out_y, out_z
  output logic [wcm_pkg::OUT_BITS-1:0]  out_tdata,
  // kind, zero_weight
  output logic [2:0]                    out_tuser,
  input  logic                          cfg_wen,
  input  logic                          cfg_wdata
);
  localparam int C  = wcm_pkg::COORD_BITS;
  localparam int IB = wcm_pkg::INDEX_BITS;
  localparam int W  = wcm_pkg::W_BITS;
  localparam int OUT_BITS_TOP = IB + 3 * C - 1;

  wcm_pkg::state_t state_r, state_nxt;
  wcm_pkg::op_t op_r, op_nxt;
  logic mode_r, mode_nxt;
  logic [W-1:0] tw_r, tw_nxt, w_r, w_nxt;
  logic [C-1:0] ref_r [3], ref_nxt [3];
  logic [C-1:0] vec_r [3], vec_nxt [3];
  logic [C-1:0] res_r [3], res_nxt [3];
  logic [63:0]  sum_r [3], sum_nxt [3];
  logic [63:0]  pm_r, pm_nxt;
  logic [IB-1:0] idx_r, idx_nxt;
  logic last_r, last_nxt;
  logic [1:0] c_r, c_nxt, kind_r, kind_nxt;
  logic zw_r, zw_nxt;
  logic ov_r, ov_nxt;
  logic [wcm_pkg::OUT_BITS-1:0] od_r, od_nxt;
  logic [2:0] ou_r, ou_nxt;

  logic mul_start, mul_done, div_start, div_done;
  logic [C-1:0] mul_src;
  logic [wcm_pkg::PROD_BITS-1:0] prod;
  logic [63:0] num_sel, quo, qc, sq, addend, sp;
  logic acc;

  assign mul_src = (op_r == wcm_pkg::OP_ACC) ? vec_r[c_r] : ref_r[c_r];
  assign num_sel = (op_r == wcm_pkg::OP_CEN) ? sum_r[c_r] : pm_r;

  wcm_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(w_r),
    .b(wcm_pkg::mag_coord(mul_src)), .done(mul_done), .prod(prod)
  );

  wcm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(wcm_pkg::mag64(num_sel)),
    .den(tw_r), .done(div_done), .quo(quo)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    mode_nxt = cfg_wen ? cfg_wdata : mode_r;
    tw_nxt = tw_r;
    w_nxt = w_r;
    ref_nxt = ref_r;
    vec_nxt = vec_r;
    res_nxt = res_r;
    sum_nxt = sum_r;
    pm_nxt = pm_r;
    idx_nxt = idx_r;
    last_nxt = last_r;
    c_nxt = c_r;
    kind_nxt = kind_r;
    zw_nxt = zw_r;
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r;
    ou_nxt = ou_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    in_tready = 1'b0;
    acc = 1'b0;
    sp = wcm_pkg::sat_prod(prod, mul_src[C-1]);
    qc = (quo > wcm_pkg::Q_CLAMP) ? wcm_pkg::Q_CLAMP : quo;
    sq = num_sel[63] ? (64'd0 - qc) : qc;
    addend = (op_r == wcm_pkg::OP_CEN) ? wcm_pkg::sext_coord(ref_r[c_r]) : 64'd0;

    case (state_r)
      wcm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          idx_nxt = in_tdata[IB-1:0];
          w_nxt = in_tdata[IB +: W];
          for (int i = 0; i < 3; i++) begin
            vec_nxt[i] = in_tdata[IB + W + i * C +: C];
          end
          last_nxt = in_tlast;
          c_nxt = 2'd0;
          if (!in_tuser) begin
            tw_nxt = in_tdata[IB +: W];
            for (int i = 0; i < 3; i++) begin
              ref_nxt[i] = in_tdata[IB + W + i * C +: C];
              sum_nxt[i] = '0;
            end
            if (mode_r) begin
              for (int i = 0; i < 3; i++) begin
                res_nxt[i] = in_tdata[IB + W + i * C +: C];
              end
              kind_nxt = wcm_pkg::KIND_REF;
              zw_nxt = 1'b0;
              state_nxt = wcm_pkg::ST_OUT;
            end else if (in_tlast) begin
              kind_nxt = wcm_pkg::KIND_CENTER;
              if (in_tdata[IB +: W] == '0) begin
                for (int i = 0; i < 3; i++) res_nxt[i] = '0;
                zw_nxt = 1'b1;
                state_nxt = wcm_pkg::ST_OUT;
              end else begin
                zw_nxt = 1'b0;
                op_nxt = wcm_pkg::OP_CEN;
                state_nxt = wcm_pkg::ST_DIV_GO;
              end
            end
          end else if (!mode_r) begin
            op_nxt = wcm_pkg::OP_ACC;
            state_nxt = wcm_pkg::ST_MUL_GO;
          end else begin
            kind_nxt = wcm_pkg::KIND_MEMBER;
            if (tw_r == '0) begin
              for (int i = 0; i < 3; i++) res_nxt[i] = '0;
              zw_nxt = 1'b1;
              state_nxt = wcm_pkg::ST_OUT;
            end else begin
              zw_nxt = 1'b0;
              op_nxt = wcm_pkg::OP_GRAD;
              state_nxt = wcm_pkg::ST_MUL_GO;
            end
          end
        end
      end
      wcm_pkg::ST_MUL_GO: begin
        mul_start = 1'b1;
        state_nxt = wcm_pkg::ST_MUL_WAIT;
      end
      wcm_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          if (op_r == wcm_pkg::OP_ACC) begin
            acc = 1'b1;
            sum_nxt[c_r] = wcm_pkg::sat_add64(sum_r[c_r], sp);
            if (c_r == 2'd2) begin
              c_nxt = 2'd0;
              if (!last_r) begin
                state_nxt = wcm_pkg::ST_IDLE;
              end else begin
                kind_nxt = wcm_pkg::KIND_CENTER;
                if (tw_r == '0) begin
                  for (int i = 0; i < 3; i++) res_nxt[i] = '0;
                  zw_nxt = 1'b1;
                  state_nxt = wcm_pkg::ST_OUT;
                end else begin
                  zw_nxt = 1'b0;
                  op_nxt = wcm_pkg::OP_CEN;
                  state_nxt = wcm_pkg::ST_DIV_GO;
                end
              end
            end else begin
              c_nxt = c_r + 2'd1;
              state_nxt = wcm_pkg::ST_MUL_GO;
            end
          end else begin
            pm_nxt = sp;
            state_nxt = wcm_pkg::ST_DIV_GO;
          end
        end
      end
      wcm_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = wcm_pkg::ST_DIV_WAIT;
      end
      wcm_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          res_nxt[c_r] = wcm_pkg::sat_coord(sq + addend);
          if (c_r == 2'd2) begin
            c_nxt = 2'd0;
            state_nxt = wcm_pkg::ST_OUT;
          end else begin
            c_nxt = c_r + 2'd1;
            state_nxt = (op_r == wcm_pkg::OP_CEN) ? wcm_pkg::ST_DIV_GO : wcm_pkg::ST_MUL_GO;
          end
        end
      end
      wcm_pkg::ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = wcm_pkg::OUT_BITS'({res_r[2], res_r[1], res_r[0], idx_r});
          ou_nxt = {zw_r, kind_r};
          if (kind_r == wcm_pkg::KIND_CENTER) begin
            for (int i = 0; i < 3; i++) sum_nxt[i] = '0;
          end
          state_nxt = wcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcm_pkg::ST_IDLE;
      op_r <= wcm_pkg::OP_ACC;
      mode_r <= 1'b0;
      ov_r <= 1'b0;
      tw_r <= '0;
      c_r <= '0;
      for (int i = 0; i < 3; i++) begin
        ref_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      mode_r <= mode_nxt;
      ov_r <= ov_nxt;
      tw_r <= tw_nxt;
      c_r <= c_nxt;
      ref_r <= ref_nxt;
      sum_r <= sum_nxt;
    end
    w_r <= w_nxt;
    vec_r <= vec_nxt;
    res_r <= res_nxt;
    pm_r <= pm_nxt;
    idx_r <= idx_nxt;
    last_r <= last_nxt;
    kind_r <= kind_nxt;
    zw_r <= zw_nxt;
    od_r <= od_nxt;
    ou_r <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata[OUT_BITS_TOP:IB] == '0)
    else $error("zero weight with nonzero vector");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] != 2'd3)
    else $error("bad kind");
  a_units: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("multiplier and divider both done");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> op_r == wcm_pkg::OP_ACC && !mode_r || op_r == wcm_pkg::OP_ACC)
    else $error("accumulate outside forward member");
`endif

endmodule
